// ===== rtl/pwas_pkg.sv =====
// shared types and constants for the pulse width average slicer
`timescale 1ns / 1ps

package pwas_pkg;

  // pulse width field width in timer ticks
  localparam int WIDTH_W = 16;

  // marks fall on every eighth bit position
  localparam int GROUP_BITS = 3;

  // input action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_END    = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/pulse_width_average_slicer.sv =====
// pulse width average slicer: sample store, serial divider and bit walk
//
// Usage: a beat is taken at a clock edge where start is high and busy is low.
// With action at sample the width goes into the store; the first width of a
// burst is kept out of the sum, and widths past DEPTH entries are dropped.
// A sample beat leaves busy low.
// With action at end of burst, a burst of n stored samples (n >= 2) gives
// n-1 result beats. The sum of the kept widths is divided by n-1 in a
// restoring divider that settles one quotient bit a cycle. The walk over
// the store then reads one entry at a time through the store's registered
// read port, in a fetch state and an emit state, and each result is shown
// for one cycle with strobe high. Busy is high while the divide and walk
// run. An end of burst with fewer than two samples gives no beat.
// Results cannot be held off; the receiver takes each strobed beat.
// Reset clears the sequencer, sample count and sum; the store is not
// cleared, since only entries written in the current burst are read.
`timescale 1ns / 1ps

module pulse_width_average_slicer
  import pwas_pkg::*;
#(
  parameter int DEPTH = 65
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [WIDTH_W-1:0] width,
  output logic               strobe,
  output logic               bit_value,
  output logic               group_mark,
  output logic [WIDTH_W-1:0] mean_width,
  output logic               last
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int IdxW  = $clog2(DEPTH);
  localparam int SumW  = WIDTH_W + IdxW;
  localparam int StepW = $clog2(SumW);
  localparam int GrpW  = (IdxW < GROUP_BITS) ? IdxW : GROUP_BITS;

  state_t state, state_next;

  logic [CntW-1:0]    count;
  logic [SumW-1:0]    sum;
  logic [IdxW-1:0]    divisor;
  logic [IdxW-1:0]    rem;
  logic [SumW-1:0]    quot;
  logic [StepW-1:0]   step;
  logic [IdxW-1:0]    idx;
  logic [IdxW-1:0]    last_idx;
  logic [WIDTH_W-1:0] rd;
  logic [WIDTH_W-1:0] store [DEPTH];

  logic accept;
  logic take_sample;
  logic end_burst;
  logic [IdxW:0]   trial;
  logic [IdxW:0]   diff;
  logic            qbit;
  logic            mark;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign take_sample = accept && (action == ACT_SAMPLE) && (count < CntW'(DEPTH));
  assign end_burst   = accept && (action == ACT_END);

  // divider step: shift in next dividend bit, trial subtract
  assign trial = {rem, quot[SumW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = (trial >= {1'b0, divisor});

  // mark on positions that are multiples of eight
  always_comb begin
    if (IdxW >= GROUP_BITS) begin
      mark = (idx[GrpW-1:0] == '0);
    end else begin
      mark = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (end_burst && (count > CntW'(1))) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == '0) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (idx == last_idx) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sample count and running sum of kept widths
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if (end_burst) begin
      count <= '0;
      sum   <= '0;
    end else if (take_sample) begin
      count <= count + CntW'(1);
      if (count != '0) begin
        sum <= sum + SumW'(width);
      end
    end
  end

  // sample store, registered read port
  always_ff @(posedge clk) begin
    if (take_sample) begin
      store[count[IdxW-1:0]] <= width;
    end
    rd <= store[idx];
  end

  // divider and walk registers
  always_ff @(posedge clk) begin
    if (end_burst && (count > CntW'(1))) begin
      divisor  <= IdxW'(count - CntW'(1));
      last_idx <= IdxW'(count - CntW'(1));
      quot     <= sum;
      rem      <= '0;
      step     <= StepW'(SumW - 1);
      idx      <= IdxW'(1);
    end else if (state == ST_DIV) begin
      rem  <= qbit ? diff[IdxW-1:0] : trial[IdxW-1:0];
      quot <= {quot[SumW-2:0], qbit};
      step <= step - StepW'(1);
    end else if (state == ST_EMIT) begin
      idx <= idx + IdxW'(1);
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      bit_value  <= (rd <= quot[WIDTH_W-1:0]);
      group_mark <= mark;
      mean_width <= quot[WIDTH_W-1:0];
      last       <= (idx == last_idx);
    end
  end

  // a result beat only follows a walk step
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_EMIT))
    else $error("result beat without walk step");

  // the final beat of a burst is never followed straight by another
  assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("beat after final beat");

  // divider never runs on a zero divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (divisor != '0))
    else $error("zero divisor in divide");

  // sample count stays within the store
  assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("sample count beyond store depth");

endmodule

// ===== verif/pulse_width_average_slicer_tb.sv =====
// testbench for the pulse width average slicer: directed table, random bursts, self-check
`timescale 1ns / 1ps

module pulse_width_average_slicer_tb
  import pwas_pkg::*;
();

  localparam int STORE_DEPTH = 65;
  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 150;
  localparam int DRAIN_WAIT  = 200;
  localparam int REPORT_MAX  = 10;

  // one emitted bit of a burst
  typedef struct packed {
    logic               bit_value;
    logic               group_mark;
    logic [WIDTH_W-1:0] mean_width;
    logic               last;
  } slice_bit_t;

  // directed row: n_typed < 0 means the predicted bits are expected
  typedef struct packed {
    logic               act;
    logic [WIDTH_W-1:0] w;
    int                 n_typed;
    slice_bit_t         typed;
  } script_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               action;
  logic [WIDTH_W-1:0] width;
  logic               strobe;
  logic               bit_value;
  logic               group_mark;
  logic [WIDTH_W-1:0] mean_width;
  logic               last;

  pulse_width_average_slicer #(.DEPTH(STORE_DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .width      (width),
    .strobe     (strobe),
    .bit_value  (bit_value),
    .group_mark (group_mark),
    .mean_width (mean_width),
    .last       (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // shadow of the block state
  logic [WIDTH_W-1:0] shadow_store [STORE_DEPTH];
  int unsigned        taken;
  logic [21:0]        kept_sum;

  slice_bit_t  burst_bits [$];
  slice_bit_t  bits_due [$];
  script_row_t script [24];

  int errors;
  int items_sent;
  int run_left;
  int idle_cycles;

  // update the shadow state and form the bits an end of burst releases
  function automatic void slice_predict(input logic act, input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] mean;
    slice_bit_t         b;
    if (act == ACT_SAMPLE) begin
      if (taken < STORE_DEPTH) begin
        shadow_store[taken] = w;
        if (taken > 0) kept_sum = kept_sum + 22'(w);
        taken++;
      end
    end else begin
      if (taken >= 2) begin
        mean = WIDTH_W'(kept_sum / 22'(taken - 1));
        for (int i = 1; i < int'(taken); i++) begin
          b.bit_value  = (shadow_store[i] > mean) ? 1'b0 : 1'b1;
          b.group_mark = ((i & ((1 << GROUP_BITS) - 1)) == 0);
          b.mean_width = mean;
          b.last       = (i == int'(taken) - 1);
          burst_bits.push_back(b);
        end
      end
      taken    = 0;
      kept_sum = '0;
    end
  endfunction

  function automatic script_row_t row(input logic act, input logic [WIDTH_W-1:0] w,
                                      input int n, input slice_bit_t typed);
    script_row_t r;
    r.act     = act;
    r.w       = w;
    r.n_typed = n;
    r.typed   = typed;
    return r;
  endfunction

  // pace the sender, hand over one beat, then log what it should produce
  task automatic send_beat(input logic act, input logic [WIDTH_W-1:0] w,
                           input int n_typed, input slice_bit_t typed);
    int gap;
    if (run_left == 0) begin
      gap      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 29) == 0) begin
        // hold off until every bit owed has come out
        start <= 1'b0;
        @(posedge clk);
        while (bits_due.size() != 0) @(posedge clk);
      end else if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) begin
          action <= 1'($urandom_range(0, 1));
          width  <= 16'($urandom_range(0, 65535));
          @(posedge clk);
        end
      end
    end
    run_left--;
    start  <= 1'b1;
    action <= act;
    width  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    slice_predict(act, w);
    if (n_typed < 0) begin
      foreach (burst_bits[i]) bits_due.push_back(burst_bits[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) bits_due.push_back(typed);
    end
    burst_bits.delete();
  endtask

  // compare each strobed bit with the oldest one owed
  always @(posedge clk) begin
    slice_bit_t exp_bit;
    if (!rst && strobe) begin
      if (bits_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected beat: bit %0d mark %0d mean %0d last %0d",
                   bit_value, group_mark, mean_width, last);
      end else begin
        exp_bit = bits_due.pop_front();
        if (bit_value !== exp_bit.bit_value || group_mark !== exp_bit.group_mark ||
            mean_width !== exp_bit.mean_width || last !== exp_bit.last) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: expected bit %0d mark %0d mean %0d last %0d, got %0d %0d %0d %0d",
                     exp_bit.bit_value, exp_bit.group_mark, exp_bit.mean_width, exp_bit.last,
                     bit_value, group_mark, mean_width, last);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          len;
    int          style;
    logic [15:0] w;
    errors      = 0;
    items_sent  = 0;
    run_left    = 0;
    idle_cycles = 0;
    taken       = 0;
    kept_sum    = '0;
    rst    <= 1'b1;
    start  <= 1'b0;
    action <= ACT_SAMPLE;
    width  <= '0;

    // directed table: empty bursts, extremes, mixed widths, a group mark
    script[0]  = row(ACT_END,    16'd0,     0,  '0);
    script[1]  = row(ACT_SAMPLE, 16'd100,   -1, '0);
    script[2]  = row(ACT_END,    16'd0,     0,  '0);
    script[3]  = row(ACT_SAMPLE, 16'd0,     -1, '0);
    script[4]  = row(ACT_SAMPLE, 16'd0,     -1, '0);
    script[5]  = row(ACT_END,    16'd0,     1,  '{1'b1, 1'b0, 16'd0, 1'b1});
    script[6]  = row(ACT_SAMPLE, 16'hFFFF,  -1, '0);
    script[7]  = row(ACT_SAMPLE, 16'hFFFF,  -1, '0);
    script[8]  = row(ACT_END,    16'hFFFF,  1,  '{1'b1, 1'b0, 16'hFFFF, 1'b1});
    script[9]  = row(ACT_SAMPLE, 16'd5,     -1, '0);
    script[10] = row(ACT_SAMPLE, 16'd0,     -1, '0);
    script[11] = row(ACT_SAMPLE, 16'hFFFF,  -1, '0);
    script[12] = row(ACT_END,    16'h5A5A,  -1, '0);
    script[13] = row(ACT_SAMPLE, 16'd7,     -1, '0);
    script[14] = row(ACT_SAMPLE, 16'd10,    -1, '0);
    script[15] = row(ACT_SAMPLE, 16'd30,    -1, '0);
    script[16] = row(ACT_SAMPLE, 16'd10,    -1, '0);
    script[17] = row(ACT_SAMPLE, 16'd30,    -1, '0);
    script[18] = row(ACT_SAMPLE, 16'd30,    -1, '0);
    script[19] = row(ACT_SAMPLE, 16'd10,    -1, '0);
    script[20] = row(ACT_SAMPLE, 16'd10,    -1, '0);
    script[21] = row(ACT_SAMPLE, 16'd30,    -1, '0);
    script[22] = row(ACT_SAMPLE, 16'd20,    -1, '0);
    script[23] = row(ACT_END,    16'd0,     -1, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_beat(script[i].act, script[i].w, script[i].n_typed, script[i].typed);

    // one burst that fills the store or runs past it, with large widths, so the sum runs high
    len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 5);
    for (int i = 0; i < len; i++)
      send_beat(ACT_SAMPLE, 16'($urandom_range(60000, 65535)), -1, '0);
    send_beat(ACT_END, 16'($urandom_range(0, 65535)), -1, '0);
    start <= 1'b0;
    @(posedge clk);
    while (bits_due.size() != 0) @(posedge clk);

    // random bursts: mostly short/long pulse codes, some raw and flat ones
    while (items_sent < ITEM_TARGET) begin
      style = $urandom_range(0, 3);
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 14);
      for (int i = 0; i < len; i++) begin
        case (style)
          0, 1: begin
            w = $urandom_range(0, 1) ? 16'($urandom_range(180, 220))
                                     : 16'($urandom_range(580, 620));
          end
          2: begin
            w = 16'($urandom_range(0, 65535));
          end
          default: begin
            w = 16'd1234;
          end
        endcase
        send_beat(ACT_SAMPLE, w, -1, '0);
      end
      send_beat(ACT_END, 16'($urandom_range(0, 65535)), -1, '0);
    end

    // drain what is still owed, then give the block time for strays
    start <= 1'b0;
    @(posedge clk);
    while (bits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (bits_due.size() != 0) errors++;

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pwas_pkg.sv
rtl/pulse_width_average_slicer.sv
verif/pulse_width_average_slicer_tb.sv
